/* design/hv_pkg.sv */
package hv_pkg;

	// Verdict codes carried in error_code
	typedef enum logic [2:0] {
		ERR_OK        = 3'd0,
		ERR_EMPTY     = 3'd1,
		ERR_TOO_LONG  = 3'd2,
		ERR_EDGE_DOT  = 3'd3,
		ERR_BAD_CHAR  = 3'd4,
		ERR_BAD_LABEL = 3'd5
	} err_code_t;

	// Configuration register indexes
	typedef enum logic {
		CFG_MAX_TOTAL = 1'b0,
		CFG_MAX_LABEL = 1'b1
	} cfg_reg_t;

	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 8;
	localparam int unsigned TOTAL_LEN_W = 8;
	localparam int unsigned LABEL_LEN_W = 6;

	localparam logic [TOTAL_LEN_W-1:0] MAX_TOTAL_RST = 8'd253;
	localparam logic [LABEL_LEN_W-1:0] MAX_LABEL_RST = 6'd63;

	localparam logic [8:0] TOTAL_SAT = 9'd511;
	localparam logic [6:0] LABEL_SAT = 7'd64;
	localparam logic [2:0] DOT_SAT   = 3'd4;
	localparam logic [2:0] DOT_QUAD  = 3'd3;
	localparam logic [3:0] LH_LEN    = 4'd9;

	localparam logic [7:0] CHAR_DOT    = 8'h2E;
	localparam logic [7:0] CHAR_HYPHEN = 8'h2D;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	// Letters of "localhost" by position
	function automatic logic [7:0] lh_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h6C; // l
			4'd1:    c = 8'h6F; // o
			4'd2:    c = 8'h63; // c
			4'd3:    c = 8'h61; // a
			4'd4:    c = 8'h6C; // l
			4'd5:    c = 8'h68; // h
			4'd6:    c = 8'h6F; // o
			4'd7:    c = 8'h73; // s
			4'd8:    c = 8'h74; // t
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

/* design/hv_in_if.sv */
interface hv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       has_char;
	logic       last;

	modport source (output valid, output character, output has_char, output last,
		input ready);
	modport sink (input valid, input character, input has_char, input last,
		output ready);
endinterface

/* design/hv_out_if.sv */
interface hv_out_if;
	logic       valid;
	logic       ready;
	logic       valid_res;
	logic [2:0] error_code;

	modport source (output valid, output valid_res, output error_code, input ready);
	modport sink (input valid, input valid_res, input error_code, output ready);
endinterface

/* design/hostname_validator_top.sv */
// Hostname validator, RFC 1123 style.
// byte_ch carries one hostname byte per transaction (character, has_char),
// with last marking the final byte of a name. A transaction with has_char
// low and last high closes a name without a byte; alone it means an empty
// name. verdict_ch carries one transaction per name: valid_res and
// error_code (ERR_OK = 0, ERR_EMPTY = 1, ERR_TOO_LONG = 2, ERR_EDGE_DOT = 3,
// ERR_BAD_CHAR = 4, ERR_BAD_LABEL = 5).
// cfg_we/cfg_index/cfg_data write max_total_length (index 0) and
// max_label_length (index 1); write them only while the block is idle.
//
// Flow: a byte taken on byte_ch sits in the input stage and is then folded into
// the name state; for a last byte the verdict goes into the output register
// instead, once that register is free, and is offered on verdict_ch from there.
// Throughput: one byte per cycle while no last byte waits on a held verdict;
// the per-byte update is counters, flags and narrow compares between the input
// stage and the state registers. Stall: while a verdict waits on verdict_ch,
// bytes that are not last keep flowing; a last byte waits in the input stage,
// and byte_ch ready stays low while it waits there.
// Reset: both limits return to 253 and 63, name state clears, both channels
// go empty.
module hostname_validator_top
	import hv_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	hv_in_if.sink                  byte_ch,
	hv_out_if.source               verdict_ch,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// Configuration registers
	logic [TOTAL_LEN_W-1:0] max_total_q;
	logic [LABEL_LEN_W-1:0] max_label_q;

	// Input stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       has_s1;
	logic       last_s1;

	// Name state
	logic [8:0] total_q;
	logic [7:0] first_q;
	logic [7:0] prev_q;
	logic [2:0] dots_q;
	logic       digits_only_q;
	logic       chars_ok_q;
	logic [6:0] label_cnt_q;
	logic       label_fault_q;
	logic [3:0] lh_idx_q;
	logic       lh_miss_q;

	// Output register
	logic       out_valid_q;
	logic       res_ok_q;
	err_code_t  res_code_q;

	// Next values after folding the staged byte in
	logic [8:0] total_n;
	logic [7:0] first_n;
	logic [7:0] prev_n;
	logic [2:0] dots_n;
	logic       digits_only_n;
	logic       chars_ok_n;
	logic [6:0] label_cnt_n;
	logic       label_fault_n;
	logic [3:0] lh_idx_n;
	logic       lh_miss_n;
	logic       final_fault;
	err_code_t  code_n;

	logic out_free;
	logic adv_s1;
	logic take_in;

	// A verdict needs the output register; other bytes never wait on it
	assign out_free = !out_valid_q || verdict_ch.ready;
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign take_in  = byte_ch.valid && byte_ch.ready;

	assign byte_ch.ready = !valid_s1 || adv_s1;

	assign verdict_ch.valid      = out_valid_q;
	assign verdict_ch.valid_res  = res_ok_q;
	assign verdict_ch.error_code = res_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_total_q <= MAX_TOTAL_RST;
			max_label_q <= MAX_LABEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_MAX_TOTAL: max_total_q <= cfg_data[TOTAL_LEN_W-1:0];
				CFG_MAX_LABEL: max_label_q <= cfg_data[LABEL_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			char_s1 <= byte_ch.character;
			has_s1  <= byte_ch.has_char;
			last_s1 <= byte_ch.last;
		end
	end

	// Byte update
	always_comb begin
		total_n       = total_q;
		first_n       = first_q;
		prev_n        = prev_q;
		dots_n        = dots_q;
		digits_only_n = digits_only_q;
		chars_ok_n    = chars_ok_q;
		label_cnt_n   = label_cnt_q;
		label_fault_n = label_fault_q;
		lh_idx_n      = lh_idx_q;
		lh_miss_n     = lh_miss_q;
		if (has_s1) begin
			if (total_q == 9'd0)
				first_n = char_s1;
			if (total_q != TOTAL_SAT)
				total_n = total_q + 9'd1;
			if ((lh_idx_q < LH_LEN) && (lh_char(lh_idx_q) == char_s1))
				lh_idx_n = lh_idx_q + 4'd1;
			else
				lh_miss_n = 1'b1;
			if (char_s1 == CHAR_DOT) begin
				if (dots_q != DOT_SAT)
					dots_n = dots_q + 3'd1;
				// label closes on the dot; empty labels are skipped
				if (label_cnt_q != 7'd0) begin
					if ((label_cnt_q > {1'b0, max_label_q}) || (prev_q == CHAR_HYPHEN))
						label_fault_n = 1'b1;
					label_cnt_n = 7'd0;
				end
			end else begin
				if (!is_digit(char_s1))
					digits_only_n = 1'b0;
				if (!is_alnum(char_s1) && (char_s1 != CHAR_HYPHEN))
					chars_ok_n = 1'b0;
				if ((label_cnt_q == 7'd0) && (char_s1 == CHAR_HYPHEN))
					label_fault_n = 1'b1;
				if (label_cnt_q != LABEL_SAT)
					label_cnt_n = label_cnt_q + 7'd1;
			end
			prev_n = char_s1;
		end
	end

	// Verdict, first matching check wins; the open label closes here
	always_comb begin
		final_fault = label_fault_n || ((label_cnt_n != 7'd0) &&
			((label_cnt_n > {1'b0, max_label_q}) || (prev_n == CHAR_HYPHEN)));
		if (total_n == 9'd0)
			code_n = ERR_EMPTY;
		else if (!lh_miss_n && (lh_idx_n == LH_LEN))
			code_n = ERR_OK;
		else if (digits_only_n && (dots_n == DOT_QUAD))
			code_n = ERR_OK;
		else if (total_n > {1'b0, max_total_q})
			code_n = ERR_TOO_LONG;
		else if ((first_n == CHAR_DOT) || (prev_n == CHAR_DOT))
			code_n = ERR_EDGE_DOT;
		else if (!chars_ok_n)
			code_n = ERR_BAD_CHAR;
		else if (final_fault)
			code_n = ERR_BAD_LABEL;
		else
			code_n = ERR_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q       <= 9'd0;
			first_q       <= 8'd0;
			prev_q        <= 8'd0;
			dots_q        <= 3'd0;
			digits_only_q <= 1'b1;
			chars_ok_q    <= 1'b1;
			label_cnt_q   <= 7'd0;
			label_fault_q <= 1'b0;
			lh_idx_q      <= 4'd0;
			lh_miss_q     <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				total_q       <= 9'd0;
				first_q       <= 8'd0;
				prev_q        <= 8'd0;
				dots_q        <= 3'd0;
				digits_only_q <= 1'b1;
				chars_ok_q    <= 1'b1;
				label_cnt_q   <= 7'd0;
				label_fault_q <= 1'b0;
				lh_idx_q      <= 4'd0;
				lh_miss_q     <= 1'b0;
			end else begin
				total_q       <= total_n;
				first_q       <= first_n;
				prev_q        <= prev_n;
				dots_q        <= dots_n;
				digits_only_q <= digits_only_n;
				chars_ok_q    <= chars_ok_n;
				label_cnt_q   <= label_cnt_n;
				label_fault_q <= label_fault_n;
				lh_idx_q      <= lh_idx_n;
				lh_miss_q     <= lh_miss_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			res_ok_q   <= (code_n == ERR_OK);
			res_code_q <= code_n;
		end
	end

	// A staged last byte with room ahead always yields a verdict
	a_verdict_issued: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> out_valid_q)
		else $error("verdict not issued for last byte");

	// valid_res agrees with error_code
	a_res_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_ok_q == (res_code_q == ERR_OK)))
		else $error("valid_res disagrees with error_code");

	// Name state starts over after a verdict
	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> ((total_q == 9'd0) && (label_cnt_q == 7'd0) &&
			(lh_idx_q == 4'd0) && !label_fault_q))
		else $error("name state not cleared after verdict");

	// Counters stay within their saturation points
	a_counter_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(dots_q <= DOT_SAT) && (label_cnt_q <= LABEL_SAT) && (lh_idx_q <= LH_LEN))
		else $error("counter beyond saturation");

	// An empty input stage never refuses a byte
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> byte_ch.ready)
		else $error("input refused with empty stage");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

// Self-checking bench for hostname_validator_top.
// Names are streamed one byte per transaction on byte_ch. Every accepted
// transaction is folded into a local model of the name checks, and each
// closing transaction queues the verdict it should produce. verdict_ch
// transactions are checked in order against that queue.
module tb_top;
	import hv_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	// "localhost" packed, first letter in the top byte
	localparam logic [71:0] LH_WORD = "localhost";

	typedef struct packed {
		logic [7:0] character;
		logic       has_char;
		logic       last;
	} byte_item_t;

	typedef struct packed {
		logic      valid_res;
		err_code_t error_code;
	} verdict_t;

	// running view of the name being received
	typedef struct packed {
		logic [8:0] total;    // bytes so far, sticks at TOTAL_SAT
		logic [7:0] head;     // first byte
		logic [7:0] prev;     // most recent byte
		logic [2:0] dots;     // dot count, sticks at DOT_SAT
		logic       numeric;  // digits and dots only
		logic       chars_ok; // alnum, hyphen and dot only
		logic [6:0] lbl_len;  // open label length, sticks at LABEL_SAT
		logic       lbl_bad;
		logic [3:0] lh_pos;   // letters of "localhost" matched
		logic       lh_miss;
	} name_track_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	hv_in_if  byte_ch ();
	hv_out_if verdict_ch ();

	byte_item_t   bytes_to_send[$]; // driver backlog, head is on the bus
	verdict_t     verdicts_due[$];  // verdicts owed by the block, oldest first
	logic [7:0]   name_buf[$];      // scratch for building one name

	name_track_t  name_st;
	logic [7:0]   lim_total;        // local copies of the two limits
	logic [5:0]   lim_label;

	bit           tx_burst;         // sender: no gaps
	bit           rx_burst;         // receiver: no stalls
	bit           rx_hold;          // receiver: hold off entirely
	int unsigned  tx_wait;
	int unsigned  rx_wait;
	int unsigned  fault_cnt = 0;
	int unsigned  cycle_cnt = 0;

	hostname_validator_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.verdict_ch(verdict_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop should the flow ever lock up
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d transactions unsent, %0d verdicts owed", $time,
				bytes_to_send.size(), verdicts_due.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// Queue appends
	function automatic void put_byte(input logic [7:0] c);
		name_buf.insert(name_buf.size(), c);
	endfunction

	function automatic void put_item(input byte_item_t it);
		bytes_to_send.insert(bytes_to_send.size(), it);
	endfunction

	// ------------------------------------------------------------------
	// Name model
	// ------------------------------------------------------------------

	function automatic name_track_t name_cleared();
		name_track_t s;
		s          = '0;
		s.numeric  = 1'b1;
		s.chars_ok = 1'b1;
		return s;
	endfunction

	function automatic logic digit_byte(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic alnum_byte(input logic [7:0] c);
		return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

	// A label closes on a dot or at the verdict; empty ones (doubled dots) are skipped.
	// Its length is judged against the limit held at that moment.
	function automatic void end_label();
		if (name_st.lbl_len != '0) begin
			if (name_st.lbl_len > 7'(lim_label) || name_st.prev == CHAR_HYPHEN)
				name_st.lbl_bad = 1'b1;
			name_st.lbl_len = '0;
		end
	endfunction

	function automatic void absorb_byte(input logic [7:0] c);
		logic hit;
		if (name_st.total == '0)
			name_st.head = c;
		if (name_st.total != TOTAL_SAT)
			name_st.total = name_st.total + 9'd1;

		if (name_st.lh_pos < LH_LEN)
			hit = LH_WORD[8*(8 - name_st.lh_pos) +: 8] == c;
		else
			hit = 1'b0;
		if (hit)
			name_st.lh_pos = name_st.lh_pos + 4'd1;
		else
			name_st.lh_miss = 1'b1;

		if (c == CHAR_DOT) begin
			if (name_st.dots != DOT_SAT)
				name_st.dots = name_st.dots + 3'd1;
			end_label();
		end else begin
			if (!digit_byte(c))
				name_st.numeric = 1'b0;
			if (!alnum_byte(c) && c != CHAR_HYPHEN)
				name_st.chars_ok = 1'b0;
			if (name_st.lbl_len == '0 && c == CHAR_HYPHEN)
				name_st.lbl_bad = 1'b1;
			if (name_st.lbl_len != LABEL_SAT)
				name_st.lbl_len = name_st.lbl_len + 7'd1;
		end
		name_st.prev = c;
	endfunction

	// First rule that applies wins
	function automatic err_code_t name_verdict();
		if (name_st.total == '0)
			return ERR_EMPTY;
		if (!name_st.lh_miss && name_st.lh_pos == LH_LEN)
			return ERR_OK;
		if (name_st.numeric && name_st.dots == DOT_QUAD)
			return ERR_OK;
		if (name_st.total > 9'(lim_total))
			return ERR_TOO_LONG;
		if (name_st.head == CHAR_DOT || name_st.prev == CHAR_DOT)
			return ERR_EDGE_DOT;
		if (!name_st.chars_ok)
			return ERR_BAD_CHAR;
		end_label();
		if (name_st.lbl_bad)
			return ERR_BAD_LABEL;
		return ERR_OK;
	endfunction

	function automatic void take_item(input byte_item_t it);
		err_code_t code;
		if (it.has_char)
			absorb_byte(it.character);
		if (it.last) begin
			code = name_verdict();
			verdicts_due.insert(verdicts_due.size(), verdict_t'({code == ERR_OK, code}));
			name_st = name_cleared();
		end
	endfunction

	function automatic void check_verdict(input logic ok, input logic [2:0] code);
		verdict_t want;
		if (verdicts_due.size() == 0) begin
			$display("%0t: verdict with none owed: expected nothing, actual ok=%0b code=%0d",
				$time, ok, code);
			fault_cnt++;
			return;
		end
		want = verdicts_due.pop_front();
		if (ok !== want.valid_res) begin
			$display("%0t: valid_res mismatch: expected %0b, actual %0b", $time,
				want.valid_res, ok);
			fault_cnt++;
		end
		if (code !== want.error_code) begin
			$display("%0t: error_code mismatch: expected %0d, actual %0d", $time,
				want.error_code, code);
			fault_cnt++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Driver: offers the head of the backlog, gap drawn per transaction
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ch.valid     <= 1'b0;
			byte_ch.character <= '0;
			byte_ch.has_char  <= 1'b0;
			byte_ch.last      <= 1'b0;
			tx_wait = 0;
		end else begin
			if (byte_ch.valid && byte_ch.ready) begin
				take_item(bytes_to_send.pop_front());
				tx_wait = tx_burst ? 0 : $urandom_range(0, 8);
			end else if (!byte_ch.valid && tx_wait != 0) begin
				tx_wait--;
			end
			// valid is never dropped while a transaction is pending on the bus
			if (tx_wait == 0 && bytes_to_send.size() != 0) begin
				byte_ch.valid <= 1'b1;
				{byte_ch.character, byte_ch.has_char, byte_ch.last} <= bytes_to_send[0];
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: stall drawn per verdict, plus the long hold-off
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_ch.ready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (verdict_ch.valid && verdict_ch.ready) begin
				check_verdict(verdict_ch.valid_res, verdict_ch.error_code);
				rx_wait = rx_burst ? 0 : $urandom_range(0, 8);
			end else if (rx_wait != 0) begin
				rx_wait--;
			end
			verdict_ch.ready <= !rx_hold && rx_wait == 0;
		end
	end

	// ------------------------------------------------------------------
	// Name builders, all writing into name_buf
	// ------------------------------------------------------------------

	function automatic logic [7:0] pick_alnum();
		int unsigned r;
		r = $urandom_range(0, 61);
		if (r < 10)
			return 8'(8'h30 + r);
		if (r < 36)
			return 8'(8'h41 + r - 10);
		return 8'(8'h61 + r - 36);
	endfunction

	function automatic logic [7:0] pick_digit();
		return 8'(8'h30 + $urandom_range(0, 9));
	endfunction

	// len bytes of well-formed labels, 1..lbl long (last to lbl+1); hyphens mid-label
	function automatic void add_host(input int unsigned len, input int unsigned lbl,
		input bit hyph);
		int unsigned run;
		int unsigned cap;
		run = 0;
		cap = $urandom_range(1, lbl);
		for (int unsigned i = 0; i < len; i++) begin
			if (run == cap && len - i >= 2) begin
				put_byte(CHAR_DOT);
				run = 0;
				cap = $urandom_range(1, lbl);
			end else begin
				if (hyph && run != 0 && run + 1 < cap && len - i >= 2 &&
					$urandom_range(0, 7) == 0)
					put_byte(CHAR_HYPHEN);
				else
					put_byte(pick_alnum());
				run++;
			end
		end
	endfunction

	function automatic void load_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(8'(s[i]));
	endfunction

	// Dotted quads, mostly right, sometimes with the wrong dot count, an empty
	// group or a stray letter
	function automatic void make_quad();
		int unsigned n_dots;
		int unsigned n_dig;
		n_dots = ($urandom_range(0, 3) != 0) ? 3 : $urandom_range(0, 5);
		for (int unsigned g = 0; g <= n_dots; g++) begin
			if (g != 0)
				put_byte(CHAR_DOT);
			n_dig = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
			repeat (n_dig)
				put_byte(pick_digit());
		end
		if (name_buf.size() != 0 && $urandom_range(0, 9) == 0)
			name_buf[$urandom_range(0, name_buf.size() - 1)] = pick_alnum();
	endfunction

	function automatic void make_localhost();
		load_text("localhost");
		case ($urandom_range(0, 7))
			0: void'(name_buf.pop_back());
			1: put_byte(8'h74);
			2: name_buf[0] = 8'h4C;               // capital L
			3: put_byte(CHAR_DOT);
			4: name_buf.push_front(8'h78);
			default: ;                            // exact match
		endcase
	endfunction

	function automatic void make_edge_dot();
		case ($urandom_range(0, 4))
			0: begin
				put_byte(CHAR_DOT);
				add_host($urandom_range(1, 12), 6, 1'b1);
			end
			1: begin
				add_host($urandom_range(1, 12), 6, 1'b1);
				put_byte(CHAR_DOT);
			end
			2: begin
				// doubled dots inside a name leave an empty label, which is skipped
				add_host($urandom_range(1, 8), 4, 1'b1);
				repeat ($urandom_range(2, 3))
					put_byte(CHAR_DOT);
				add_host($urandom_range(1, 8), 4, 1'b1);
			end
			3: repeat ($urandom_range(1, 5)) put_byte(CHAR_DOT);
			default: begin
				put_byte(CHAR_DOT);
				add_host($urandom_range(1, 6), 3, 1'b0);
				put_byte(CHAR_DOT);
			end
		endcase
	endfunction

	function automatic void make_hyphen_fault();
		case ($urandom_range(0, 4))
			0: begin
				put_byte(CHAR_HYPHEN);
				add_host($urandom_range(1, 10), 5, 1'b1);
			end
			1: begin
				add_host($urandom_range(1, 10), 5, 1'b1);
				put_byte(CHAR_HYPHEN);
			end
			2: begin
				add_host($urandom_range(1, 6), 3, 1'b0);
				put_byte(CHAR_HYPHEN);
				put_byte(CHAR_DOT);
				add_host($urandom_range(1, 6), 3, 1'b0);
			end
			3: begin
				add_host($urandom_range(1, 6), 3, 1'b0);
				put_byte(CHAR_DOT);
				put_byte(CHAR_HYPHEN);
				add_host($urandom_range(1, 6), 3, 1'b0);
			end
			default: repeat ($urandom_range(1, 3)) put_byte(CHAR_HYPHEN);
		endcase
	endfunction

	// Anything at all, weighted towards the bytes the checks care about
	function automatic void make_noise();
		int unsigned r;
		repeat ($urandom_range(1, 12)) begin
			r = $urandom_range(0, 9);
			if (r < 5)
				put_byte(8'($urandom_range(0, 255)));
			else if (r < 7)
				put_byte(CHAR_DOT);
			else if (r < 8)
				put_byte(CHAR_HYPHEN);
			else
				put_byte(pick_alnum());
		end
	endfunction

	// One label sized around the current label limit
	function automatic void make_long_label();
		int unsigned len;
		len = int'(lim_label) + $urandom_range(0, 3);
		len = (len > 1) ? len - 1 : 1;
		if ($urandom_range(0, 1) != 0) begin
			add_host($urandom_range(1, 5), 5, 1'b0);
			put_byte(CHAR_DOT);
		end
		repeat (len)
			put_byte(pick_alnum());
		if ($urandom_range(0, 2) == 0) begin
			put_byte(CHAR_DOT);
			add_host($urandom_range(1, 5), 5, 1'b0);
		end
	endfunction

	// Whole name sized around the current total limit
	function automatic void make_near_total();
		int unsigned len;
		int unsigned lbl;
		len = int'(lim_total) + $urandom_range(0, 4);
		len = (len > 2) ? len - 2 : 1;
		lbl = (lim_label == '0) ? 1 : ((lim_label > 30) ? 30 : int'(lim_label));
		add_host(len, lbl, 1'b1);
	endfunction

	// Turns name_buf into transactions. Unless plain, filler transactions with
	// no byte are sprinkled in and some names close on a byte-less transaction.
	// Returns the count of transactions that matter to the block.
	function automatic int unsigned queue_name(input bit plain);
		int unsigned n;
		bit          tail_close;
		n = 0;
		if (name_buf.size() == 0) begin
			put_item(byte_item_t'({8'($urandom_range(0, 255)), 1'b0, 1'b1}));
			return 1;
		end
		tail_close = !plain && $urandom_range(0, 6) == 0;
		foreach (name_buf[i]) begin
			if (!plain && $urandom_range(0, 19) == 0)
				put_item(byte_item_t'({8'($urandom_range(0, 255)), 1'b0, 1'b0}));
			put_item(byte_item_t'({name_buf[i], 1'b1,
				!tail_close && i == name_buf.size() - 1}));
			n++;
		end
		if (tail_close) begin
			put_item(byte_item_t'({8'($urandom_range(0, 255)), 1'b0, 1'b1}));
			n++;
		end
		name_buf.delete();
		return n;
	endfunction

	function automatic void fill_names(input int unsigned target);
		int unsigned sent;
		int unsigned pick;
		int unsigned big_cut;
		sent    = 0;
		// full-length names are costly at large limits, so keep them rare there
		big_cut = (lim_total > 64) ? 98 : 92;
		while (sent < target) begin
			name_buf.delete();
			pick = $urandom_range(0, 99);
			if (pick < 2)
				; // empty name
			else if (pick < 36)
				add_host($urandom_range(1, 24), $urandom_range(1, 8), 1'b1);
			else if (pick < 48)
				make_quad();
			else if (pick < 53)
				make_localhost();
			else if (pick < 61)
				make_edge_dot();
			else if (pick < 69)
				make_hyphen_fault();
			else if (pick < 80)
				make_noise();
			else if (pick < big_cut)
				make_long_label();
			else
				make_near_total();
			sent += queue_name(1'b0);
		end
	endfunction

	// ------------------------------------------------------------------
	// Sequencing
	// ------------------------------------------------------------------

	// Only with the block idle: nothing unsent, nothing owed, pipe flushed
	task automatic write_limits(input logic [7:0] total_val, input logic [7:0] label_val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MAX_TOTAL;
		cfg_data  <= total_val;
		@(posedge clk);
		cfg_index <= CFG_MAX_LABEL;
		cfg_data  <= label_val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		lim_total = total_val;
		lim_label = label_val[5:0];
	endtask

	// Waits until nothing is unsent and every verdict is back, then keeps waiting to
	// cover a trailing byte-less transaction still in the input stage
	task automatic drain();
		while (bytes_to_send.size() != 0 || verdicts_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input int unsigned n_items);
		@(negedge clk);
		fill_names(n_items);
		drain();
	endtask

	initial begin
		cfg_we    = 1'b0;
		cfg_index = CFG_MAX_TOTAL;
		cfg_data  = '0;
		tx_burst  = 1'b0;
		rx_burst  = 1'b0;
		rx_hold   = 1'b0;
		lim_total = MAX_TOTAL_RST;
		lim_label = MAX_LABEL_RST;
		name_st   = name_cleared();
		// high then low in the same step, so the reset branches see a clean edge
		arst_n = 1'b1;
		#0 arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed names at the reset limits
		@(negedge clk);
		void'(queue_name(1'b1));                   // empty name
		load_text("localhost");
		void'(queue_name(1'b1));
		load_text("...");                          // three bare dots pass as a quad
		void'(queue_name(1'b1));
		load_text("1.2.3.4");
		void'(queue_name(1'b1));
		put_byte(8'hFF);                           // top-half byte
		void'(queue_name(1'b1));
		put_byte(8'h00);
		void'(queue_name(1'b1));
		load_text("-");                            // hyphen at both label ends
		void'(queue_name(1'b1));
		load_text(".a");                           // leading dot
		void'(queue_name(1'b1));
		// byte-less filler has no effect, then a one-byte name
		put_item(byte_item_t'({8'hAA, 1'b0, 1'b0}));
		put_item(byte_item_t'({8'h7A, 1'b1, 1'b1}));
		// name closed by a byte-less transaction
		put_item(byte_item_t'({8'h61, 1'b1, 1'b0}));
		put_item(byte_item_t'({8'h55, 1'b0, 1'b1}));
		drain();

		// Random names at the reset limits
		run_phase(150);

		// Back-pressure: sender flat out while the receiver holds off, so the
		// input stage fills and byte_ch stalls
		tx_burst = 1'b1;
		@(negedge clk);
		fill_names(120);
		rx_hold = 1'b1;
		repeat (300) @(negedge clk);
		rx_hold = 1'b0;
		drain();
		tx_burst = 1'b0;

		// Widest total limit; long names hit the saturating counters
		write_limits(8'd255, 8'd63);
		@(negedge clk);
		add_host(520, 63, 1'b1);
		void'(queue_name(1'b0));
		repeat (140) put_byte(pick_alnum());
		void'(queue_name(1'b0));
		drain();
		tx_burst = 1'b1;                           // a stretch with no idling
		rx_burst = 1'b1;
		run_phase(80);
		tx_burst = 1'b0;
		rx_burst = 1'b0;

		// Tightest legal limits
		write_limits(8'd1, 8'd1);
		run_phase(100);

		// Zero limits: every label faults, every non-empty name but localhost and quads is too long
		write_limits(8'd0, 8'd0);
		run_phase(80);

		// Mid-sized limits, with a full pause between the two halves
		write_limits(8'd20, 8'd5);
		run_phase(80);
		run_phase(80);

		repeat (3) begin
			write_limits(8'($urandom_range(1, 255)), 8'($urandom_range(1, 63)));
			tx_burst = 1'($urandom_range(0, 1));
			rx_burst = 1'($urandom_range(0, 1));
			run_phase(80);
		end
		tx_burst = 1'b0;
		rx_burst = 1'b0;

		// Label write wider than the register: only the low six bits land
		write_limits(8'd64, 8'hFF);
		run_phase(80);

		repeat (10) @(posedge clk);
		if (fault_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
